/* design/decimal_integer_parser_unit_assert.svh */
// ----------------------------------------------------------------------------
// Decimal integer parser assertion macros
// Shared assertion macros for the decimal integer parser unit. The checking
// form is used in simulation; synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_INTEGER_PARSER_UNIT_ASSERT_SVH
`define DECIMAL_INTEGER_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is high.
`define DIP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("decimal parser check failed");

// Next-cycle implication, disabled while reset is high.
`define DIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("decimal parser check failed");

`else

`define DIP_ASSERT_NOW(label, clk, rst, ante, cons)
`define DIP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* design/dip_pkg.sv */
// ----------------------------------------------------------------------------
// Decimal integer parser package
// Widths and the control bundle shared by the parser modules.
// ----------------------------------------------------------------------------
package dip_pkg;

   // Width of the accumulated magnitude; the result is sign-extended to 64.
   localparam int VALUE_WIDTH = 64;
   localparam int RESULT_WIDTH = 64;
   localparam int CHAR_WIDTH = 8;

   // Character codes the parser cares about.
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE = 8'h39;

   // Control from the phase sequencer to the datapath and result register.
   typedef struct packed {
      logic add_digit;   // fold the current digit into the magnitude
      logic clear;       // terminator processed: return to start state
      logic negative;    // a leading minus was seen
      logic ok;          // text so far forms a valid literal
   } dip_ctrl_type;

endpackage

/* design/dip_phase_ctrl.sv */
// ----------------------------------------------------------------------------
// Decimal integer parser phase sequencer
// Classifies each character and steps the parse phase and sign flag.
// ----------------------------------------------------------------------------
module dip_phase_ctrl
   import dip_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [CHAR_WIDTH-1:0] ch,
   input  logic                  term,
   output dip_ctrl_type          ctrl
);

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_SIGN,
      PH_DIGIT,
      PH_TRAIL,
      PH_ERROR
   } phase_type;

   phase_type phase_ff, phase_in;
   logic      negative_ff, negative_in;
   logic      is_digit;
   logic      is_space;
   logic      add_digit;

   // Character classes.
   always_comb begin
      is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      is_space = ch inside {8'h20, 8'h0A, 8'h09, 8'h0D, 8'h0B, 8'h0C};
   end

   // Next phase and sign flag for one request.
   always_comb begin
      phase_in = phase_ff;
      negative_in = negative_ff;
      add_digit = 1'b0;
      if (fire && term) begin
         phase_in = PH_LEAD;
         negative_in = 1'b0;
      end else if (fire) begin
         case (phase_ff)
            PH_LEAD: begin
               if (is_space) begin
                  phase_in = PH_LEAD;
               end else if (ch == CHAR_MINUS) begin
                  negative_in = 1'b1;
                  phase_in = PH_SIGN;
               end else if (is_digit) begin
                  add_digit = 1'b1;
                  phase_in = PH_DIGIT;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_SIGN, PH_DIGIT: begin
               if (is_digit) begin
                  add_digit = 1'b1;
                  phase_in = PH_DIGIT;
               end else if (is_space) begin
                  phase_in = PH_TRAIL;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_TRAIL: begin
               if (!is_space) begin
                  phase_in = PH_ERROR;
               end
            end
            default: begin
               phase_in = PH_ERROR;
            end
         endcase
      end
   end

   // Phase and sign registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         negative_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         negative_ff <= negative_in;
      end
   end

   // A literal is complete once at least one digit or the sign-then-space
   // case has been seen.
   assign ctrl.add_digit = add_digit;
   assign ctrl.clear = fire && term;
   assign ctrl.negative = negative_ff;
   assign ctrl.ok = (phase_ff == PH_DIGIT) || (phase_ff == PH_TRAIL);

endmodule

/* design/dip_digit_acc.sv */
// ----------------------------------------------------------------------------
// Decimal integer parser digit accumulator
// Multiplies the magnitude by ten and adds a digit, tracking overflow.
// ----------------------------------------------------------------------------
module dip_digit_acc
   import dip_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  dip_ctrl_type           ctrl,
   input  logic [CHAR_WIDTH-1:0]  ch,
   output logic [VALUE_WIDTH-1:0] acc,
   output logic                   overflowed
);

   localparam logic [VALUE_WIDTH-1:0] MAX_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

   // Largest magnitude that still takes digit d without passing MAX_POS.
   localparam logic [VALUE_WIDTH-1:0] DIGIT_LIMIT [0:9] = '{
      MAX_POS / 10, (MAX_POS - 1) / 10, (MAX_POS - 2) / 10, (MAX_POS - 3) / 10,
      (MAX_POS - 4) / 10, (MAX_POS - 5) / 10, (MAX_POS - 6) / 10,
      (MAX_POS - 7) / 10, (MAX_POS - 8) / 10, (MAX_POS - 9) / 10
   };

   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   ovf_ff, ovf_in;
   logic [3:0]             digit;
   logic [VALUE_WIDTH-1:0] limit;
   logic [VALUE_WIDTH-1:0] scaled;

   assign digit = ch[3:0];

   // Overflow threshold for the current digit.
   always_comb begin
      case (digit)
         4'd0: limit = DIGIT_LIMIT[0];
         4'd1: limit = DIGIT_LIMIT[1];
         4'd2: limit = DIGIT_LIMIT[2];
         4'd3: limit = DIGIT_LIMIT[3];
         4'd4: limit = DIGIT_LIMIT[4];
         4'd5: limit = DIGIT_LIMIT[5];
         4'd6: limit = DIGIT_LIMIT[6];
         4'd7: limit = DIGIT_LIMIT[7];
         4'd8: limit = DIGIT_LIMIT[8];
         4'd9: limit = DIGIT_LIMIT[9];
         default: limit = '0;
      endcase
   end

   // Times ten as two shifts and an add; wraps at the value width.
   assign scaled = (acc_ff << 3) + (acc_ff << 1)
                 + {{(VALUE_WIDTH-4){1'b0}}, digit};

   always_comb begin
      acc_in = acc_ff;
      ovf_in = ovf_ff;
      if (ctrl.clear) begin
         acc_in = '0;
         ovf_in = 1'b0;
      end else if (ctrl.add_digit) begin
         acc_in = scaled;
         if (acc_ff > limit) begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         ovf_ff <= ovf_in;
      end
   end

   assign acc = acc_ff;
   assign overflowed = ovf_ff;

endmodule

/* design/dip_out_reg.sv */
// ----------------------------------------------------------------------------
// Decimal integer parser result register
// Applies the sign, extends to 64 bits and holds the result for the response
// channel.
// ----------------------------------------------------------------------------
module dip_out_reg
   import dip_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  dip_ctrl_type            ctrl,
   input  logic [VALUE_WIDTH-1:0]  acc,
   input  logic                    overflowed,
   output logic                    slot_free,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RESULT_WIDTH-1:0] rsp_tdata,  // [63:0] value
   output logic [1:0]              rsp_tuser   // [0] invalid, [1] overflow
);

   logic                    valid_ff, valid_in;
   logic [RESULT_WIDTH-1:0] value_ff, value_in;
   logic                    invalid_ff, invalid_in;
   logic                    ovf_ff, ovf_in;
   logic [VALUE_WIDTH-1:0]  magnitude;

   // Signed value, or zero with the invalid flag.
   always_comb begin
      magnitude = ctrl.negative ? (~acc + 1'b1) : acc;
      if (ctrl.ok) begin
         value_in = RESULT_WIDTH'(signed'(magnitude));
      end else begin
         value_in = '0;
      end
      invalid_in = !ctrl.ok;
      ovf_in = ctrl.ok && overflowed;
   end

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads only when a terminator is processed.
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         value_ff <= value_in;
         invalid_ff <= invalid_in;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = value_ff;
   assign rsp_tuser = {ovf_ff, invalid_ff};

endmodule

/* design/decimal_integer_parser_unit.sv */
// A terminator request reaches its result through the input register, then the
// result register.
// Throughput: one request per cycle; the magnitude update is one shift-add.
// A terminator stalls only while the previous result is still held.
// Reset is synchronous and active high; it returns the parser to its start state.
// ----------------------------------------------------------------------------
// Decimal integer parser unit
// Parses ASCII decimal text, one character per request, into a signed value.
// ----------------------------------------------------------------------------
`include "decimal_integer_parser_unit_assert.svh"

module decimal_integer_parser_unit
   import dip_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [CHAR_WIDTH-1:0]   req_tdata,  // [7:0] ch
   input  logic                    req_tlast,  // terminator
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RESULT_WIDTH-1:0] rsp_tdata,  // [63:0] value
   output logic [1:0]              rsp_tuser   // [0] invalid, [1] overflow
);

   logic                   s1_valid_ff, s1_valid_in;
   logic [CHAR_WIDTH-1:0]  s1_ch_ff;
   logic                   s1_term_ff;
   logic                   s1_fire;
   logic                   slot_free;
   logic                   req_accept;
   dip_ctrl_type           ctrl;
   logic [VALUE_WIDTH-1:0] acc;
   logic                   overflowed;

   // Input register; a held terminator waits for the result slot.
   assign s1_fire = s1_valid_ff && (!s1_term_ff || slot_free);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ch_ff <= req_tdata;
         s1_term_ff <= req_tlast;
      end
   end

   dip_phase_ctrl u_phase (
      .clock (clock),
      .reset (reset),
      .fire  (s1_fire),
      .ch    (s1_ch_ff),
      .term  (s1_term_ff),
      .ctrl  (ctrl)
   );

   dip_digit_acc u_acc (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .ch         (s1_ch_ff),
      .acc        (acc),
      .overflowed (overflowed)
   );

   dip_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .acc        (acc),
      .overflowed (overflowed),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // An invalid result carries a zero value and no overflow flag.
   `DIP_ASSERT_NOW(a_invalid_clean, clock, reset, rsp_tvalid && rsp_tuser[0],
                   rsp_tdata == '0 && !rsp_tuser[1])

   // A processed terminator leaves the accumulator cleared.
   `DIP_ASSERT_NEXT(a_term_clears, clock, reset, s1_fire && s1_term_ff, acc == '0 && !overflowed)

   // A processed terminator always presents a result.
   `DIP_ASSERT_NEXT(a_term_result, clock, reset, s1_fire && s1_term_ff, rsp_tvalid)

endmodule
